FILE: rtl/icti_pkg.sv
// Shared constants, market table and types for the instrument code to index converter.
`timescale 1ns / 1ps

package icti_pkg;

   localparam int MAX_CODE_LEN_DEF = 12;
   localparam int QUEUE_DEPTH      = 2;

   localparam int CHAR_W     = 8;
   localparam int INDEX_W    = 24;
   localparam int SUF_BYTES  = 5;
   localparam int SUF_W      = SUF_BYTES * CHAR_W;
   localparam int SL_W       = 3;
   localparam int NUM_MKT    = 13;
   localparam int MKT_W      = 4;
   localparam int KIND_W     = 2;
   localparam int VAL_W      = 20;
   localparam int MONTH_BITS = 10;
   localparam int ALPHA_W    = 10;

   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UPPER = 8'h41;
   localparam logic [CHAR_W-1:0] CH_LOWER = 8'h61;
   localparam logic [CHAR_W-1:0] ALPHA_SPAN = 8'd25;

   localparam logic [SL_W-1:0] SL_SAT = SL_W'(SUF_BYTES + 1);

   // market kinds
   localparam logic [KIND_W-1:0] KIND_D6 = 2'd0;
   localparam logic [KIND_W-1:0] KIND_D5 = 2'd1;
   localparam logic [KIND_W-1:0] KIND_UP = 2'd2;
   localparam logic [KIND_W-1:0] KIND_LO = 2'd3;

   localparam int SZ_D6    = 1000000;
   localparam int SZ_D5    = 100000;
   localparam int SZ_C1    = 26624;
   localparam int SZ_C2    = 692224;
   localparam int FUT_BASE = 5 * SZ_D6 + SZ_D5;
   localparam int FUT_PAIR = SZ_C1 + SZ_C2;

   // suffix names, right aligned: the last byte of the name sits in the low byte
   localparam logic [SUF_W-1:0] MKT_NAME [NUM_MKT] = '{
      40'h5348, 40'h535A, 40'h424A, 40'h435349, 40'h434E49, 40'h484B,
      40'h4346464558, 40'h53484645, 40'h444345, 40'h435A4345,
      40'h474645, 40'h494E45, 40'h534745
   };

   localparam logic [SL_W-1:0] MKT_LEN [NUM_MKT] = '{
      3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd2, 3'd5, 3'd4, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3
   };

   localparam logic [KIND_W-1:0] MKT_KIND [NUM_MKT] = '{
      KIND_D6, KIND_D6, KIND_D6, KIND_D6, KIND_D6, KIND_D5,
      KIND_UP, KIND_LO, KIND_LO, KIND_UP, KIND_LO, KIND_LO, KIND_UP
   };

   localparam logic [INDEX_W-1:0] MKT_BASE1 [NUM_MKT] = '{
      INDEX_W'(0),         INDEX_W'(SZ_D6),     INDEX_W'(2 * SZ_D6),
      INDEX_W'(3 * SZ_D6), INDEX_W'(4 * SZ_D6), INDEX_W'(5 * SZ_D6),
      INDEX_W'(FUT_BASE + 0 * FUT_PAIR), INDEX_W'(FUT_BASE + 1 * FUT_PAIR),
      INDEX_W'(FUT_BASE + 2 * FUT_PAIR), INDEX_W'(FUT_BASE + 3 * FUT_PAIR),
      INDEX_W'(FUT_BASE + 4 * FUT_PAIR), INDEX_W'(FUT_BASE + 5 * FUT_PAIR),
      INDEX_W'(FUT_BASE + 6 * FUT_PAIR)
   };

   // classification handed from the front to the back
   typedef struct packed {
      logic              ok;
      logic [MKT_W-1:0]  market;
   } icti_class_type;

   function automatic icti_class_type classify(input logic [SUF_W-1:0] suf,
                                               input logic [SL_W-1:0]  sl);
      icti_class_type res;
      res = '0;
      for (int k = NUM_MKT - 1; k >= 0; k--) begin
         if (sl == MKT_LEN[k] && suf == MKT_NAME[k]) begin
            res.ok     = 1'b1;
            res.market = MKT_W'(k);
         end
      end
      return res;
   endfunction

   function automatic logic [KIND_W-1:0] mkt_kind(input logic [MKT_W-1:0] idx);
      logic [KIND_W-1:0] res;
      res = KIND_D6;
      if (int'(idx) < NUM_MKT) begin
         res = MKT_KIND[idx];
      end
      return res;
   endfunction

   function automatic logic [INDEX_W-1:0] mkt_base1(input logic [MKT_W-1:0] idx);
      logic [INDEX_W-1:0] res;
      res = '0;
      if (int'(idx) < NUM_MKT) begin
         res = MKT_BASE1[idx];
      end
      return res;
   endfunction

endpackage

FILE: rtl/icti_front.sv
// Front end: takes one character per cycle unless queue_full, tracks the last dot and suffix, classifies the market.
`timescale 1ns / 1ps

module icti_front import icti_pkg::*; #(
   parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [CHAR_W-1:0]                req_code_char,
   input  logic                             req_last_char,
   input  logic                             queue_full,
   output logic                             push,
   output logic [MAX_CODE_LEN*CHAR_W-1:0]   push_buf,
   output logic [$clog2(MAX_CODE_LEN)-1:0]  push_prefix_len,
   output icti_class_type                   push_class
);

   localparam int LEN_W = $clog2(MAX_CODE_LEN + 2);
   localparam int IDX_W = $clog2(MAX_CODE_LEN);
   localparam int BUF_W = MAX_CODE_LEN * CHAR_W;

   logic [LEN_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] dot_ff, dot_in;
   logic             found_ff, found_in;
   logic [SUF_W-1:0] suf_ff, suf_in;
   logic [SL_W-1:0]  sl_ff, sl_in;
   logic [BUF_W-1:0] buf_ff, buf_in;

   logic             accept;
   logic             store;
   logic [LEN_W-1:0] cnt_n;
   logic [IDX_W-1:0] dot_n;
   logic             found_n;
   logic [SUF_W-1:0] suf_n;
   logic [SL_W-1:0]  sl_n;
   icti_class_type   cls;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign store     = count_ff < LEN_W'(MAX_CODE_LEN);

   always_comb begin
      buf_in  = buf_ff;
      cnt_n   = count_ff;
      dot_n   = dot_ff;
      found_n = found_ff;
      suf_n   = suf_ff;
      sl_n    = sl_ff;
      if (accept) begin
         if (store) begin
            for (int i = 0; i < MAX_CODE_LEN; i++) begin
               if (count_ff == LEN_W'(i)) begin
                  buf_in[i*CHAR_W +: CHAR_W] = req_code_char;
               end
            end
            cnt_n = count_ff + LEN_W'(1);
            if (req_code_char == CH_DOT) begin
               // a new dot restarts the suffix
               dot_n   = count_ff[IDX_W-1:0];
               found_n = 1'b1;
               suf_n   = '0;
               sl_n    = '0;
            end else begin
               suf_n = {suf_ff[SUF_W-CHAR_W-1:0], req_code_char};
               if (sl_ff != SL_SAT) begin
                  sl_n = sl_ff + SL_W'(1);
               end
            end
         end else begin
            cnt_n = LEN_W'(MAX_CODE_LEN + 1);
         end
      end

      cls    = classify(suf_n, sl_n);
      cls.ok = cls.ok && found_n && dot_n != '0
               && cnt_n >= LEN_W'(3) && cnt_n <= LEN_W'(MAX_CODE_LEN);

      count_in = cnt_n;
      dot_in   = dot_n;
      found_in = found_n;
      suf_in   = suf_n;
      sl_in    = sl_n;
      if (accept && req_last_char) begin
         count_in = '0;
         found_in = 1'b0;
         suf_in   = '0;
         sl_in    = '0;
      end
   end

   assign push            = accept && req_last_char;
   assign push_buf        = buf_in;
   assign push_prefix_len = dot_n;
   assign push_class      = cls;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         found_ff <= 1'b0;
         sl_ff    <= '0;
         suf_ff   <= '0;
      end else begin
         count_ff <= count_in;
         found_ff <= found_in;
         sl_ff    <= sl_in;
         suf_ff   <= suf_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      dot_ff <= dot_in;
   end

endmodule

FILE: rtl/icti_queue.sv
// Short request queue between the front end and the conversion back end.
`timescale 1ns / 1ps

module icti_queue import icti_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign full      = cnt_ff == CNT_W'(QUEUE_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/icti_back.sv
// Back end: walks the prefix one character per cycle and builds the dense index.
`timescale 1ns / 1ps

module icti_back import icti_pkg::*; #(
   parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   output logic                             q_pop,
   input  logic [MAX_CODE_LEN*CHAR_W-1:0]   q_buf,
   input  logic [$clog2(MAX_CODE_LEN)-1:0]  q_prefix_len,
   input  icti_class_type                   q_class,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [INDEX_W-1:0]               rsp_code_index,
   output logic                             rsp_index_valid
);

   localparam int IDX_W = $clog2(MAX_CODE_LEN);
   localparam int BUF_W = MAX_CODE_LEN * CHAR_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_PARSE  = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [BUF_W-1:0]    sh_ff, sh_in;
   logic [IDX_W-1:0]    rem_ff, rem_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [INDEX_W-1:0]  base1_ff, base1_in;
   logic [INDEX_W-1:0]  base_ff, base_in;
   logic                ok_ff, ok_in;
   logic [1:0]          phase_ff, phase_in;
   logic                two_ff, two_in;
   logic [ALPHA_W-1:0]  alpha_ff, alpha_in;
   logic [VAL_W-1:0]    acc_ff, acc_in;
   logic [6:0]          yy_ff, yy_in;
   logic [6:0]          mm_ff, mm_in;
   logic [2:0]          dc_ff, dc_in;
   logic [VAL_W-1:0]    val_ff, val_in;
   logic                out_valid_ff, out_valid_in;
   logic [INDEX_W-1:0]  out_idx_ff, out_idx_in;
   logic                out_iv_ff, out_iv_in;

   logic [CHAR_W-1:0]   ch;
   logic [CHAR_W-1:0]   lo;
   logic                is_dig;
   logic                is_let;
   logic [3:0]          dig;
   logic [4:0]          let_val;
   logic                out_free;
   logic                len_ok;
   logic                futures;
   logic [10:0]         mag;
   logic [INDEX_W-1:0]  sum;

   assign ch       = sh_ff[CHAR_W-1:0];
   assign futures  = kind_ff == KIND_UP || kind_ff == KIND_LO;
   assign lo       = (kind_ff == KIND_UP) ? CH_UPPER : CH_LOWER;
   assign is_dig   = ch >= CH_ZERO && ch <= CH_NINE;
   assign is_let   = ch >= lo && ch <= lo + ALPHA_SPAN;
   assign dig      = 4'(ch - CH_ZERO);
   assign let_val  = 5'(ch - lo);
   assign out_free = !out_valid_ff || !rsp_stall;
   assign mag      = 11'(yy_ff) * 11'd12 + 11'(mm_ff) - 11'd1;
   assign sum      = base_ff + INDEX_W'(val_ff);

   always_comb begin
      case (mkt_kind(q_class.market))
         KIND_D6: len_ok = q_prefix_len == IDX_W'(6);
         KIND_D5: len_ok = q_prefix_len == IDX_W'(5);
         default: len_ok = q_prefix_len == IDX_W'(5) || q_prefix_len == IDX_W'(6);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      sh_in        = sh_ff;
      rem_in       = rem_ff;
      kind_in      = kind_ff;
      base1_in     = base1_ff;
      base_in      = base_ff;
      ok_in        = ok_ff;
      phase_in     = phase_ff;
      two_in       = two_ff;
      alpha_in     = alpha_ff;
      acc_in       = acc_ff;
      yy_in        = yy_ff;
      mm_in        = mm_ff;
      dc_in        = dc_ff;
      val_in       = val_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_idx_in   = out_idx_ff;
      out_iv_in    = out_iv_ff;
      q_pop        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               sh_in    = q_buf;
               rem_in   = q_prefix_len;
               kind_in  = mkt_kind(q_class.market);
               base1_in = mkt_base1(q_class.market);
               ok_in    = q_class.ok && len_ok;
               phase_in = '0;
               two_in   = 1'b0;
               alpha_in = '0;
               acc_in   = '0;
               yy_in    = '0;
               mm_in    = '0;
               dc_in    = '0;
               state_in = (q_class.ok && len_ok) ? ST_PARSE : ST_EMIT;
            end
         end
         ST_PARSE: begin
            sh_in  = sh_ff >> CHAR_W;
            rem_in = rem_ff - IDX_W'(1);
            if (!futures) begin
               acc_in = acc_ff * VAL_W'(10) + VAL_W'(dig);
               if (!is_dig) begin
                  ok_in = 1'b0;
               end
            end else begin
               // letters first (one or two), then exactly four digits YYMM
               case (phase_ff)
                  2'd0: begin
                     alpha_in = ALPHA_W'(let_val);
                     if (!is_let) begin
                        ok_in = 1'b0;
                     end
                     phase_in = 2'd1;
                  end
                  2'd1: begin
                     if (is_let) begin
                        alpha_in = alpha_ff * ALPHA_W'(26) + ALPHA_W'(let_val);
                        two_in   = 1'b1;
                     end else if (!is_dig) begin
                        ok_in = 1'b0;
                     end
                     phase_in = 2'd2;
                  end
                  default: begin
                     if (!is_dig) begin
                        ok_in = 1'b0;
                     end
                  end
               endcase
               if (is_dig && !(phase_ff == 2'd1 && is_let) && phase_ff != 2'd0) begin
                  if (dc_ff < 3'd2) begin
                     yy_in = yy_ff * 7'd10 + 7'(dig);
                  end else if (dc_ff < 3'd4) begin
                     mm_in = mm_ff * 7'd10 + 7'(dig);
                  end
                  if (dc_ff != 3'd5) begin
                     dc_in = dc_ff + 3'd1;
                  end
               end
            end
            if (rem_ff == IDX_W'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!futures) begin
               val_in  = acc_ff;
               base_in = base1_ff;
            end else begin
               val_in  = {alpha_ff, mag[MONTH_BITS-1:0]};
               base_in = two_ff ? base1_ff + INDEX_W'(SZ_C1) : base1_ff;
               if (dc_ff != 3'd4 || mm_ff < 7'd1 || mm_ff > 7'd12 || mag > 11'd1023) begin
                  ok_in = 1'b0;
               end
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_idx_in   = ok_ff ? sum : '0;
               out_iv_in    = ok_ff && sum != '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff      <= sh_in;
      rem_ff     <= rem_in;
      kind_ff    <= kind_in;
      base1_ff   <= base1_in;
      base_ff    <= base_in;
      ok_ff      <= ok_in;
      phase_ff   <= phase_in;
      two_ff     <= two_in;
      alpha_ff   <= alpha_in;
      acc_ff     <= acc_in;
      yy_ff      <= yy_in;
      mm_ff      <= mm_in;
      dc_ff      <= dc_in;
      val_ff     <= val_in;
      out_idx_ff <= out_idx_in;
      out_iv_ff  <= out_iv_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_code_index  = out_idx_ff;
   assign rsp_index_valid = out_iv_ff;

endmodule

FILE: rtl/instrument_code_to_index_core.sv
// Top level of the instrument code to dense index converter.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_code_char[7:0], req_last_char
//   rsp     | out       | rsp_valid/rsp_stall | rsp_code_index[23:0], rsp_index_valid
//
// The front end takes one character per cycle; req_stall is high only while the
// two-entry code queue is full. The back sequencer handles one code at a time: it
// loads the code, walks the prefix character by character, finishes and emits;
// codes rejected at classification go from load straight to emit.
// Reset is synchronous and clears the character count, queue and sequencer.
// A stalled result holds in the output register; the back end waits on it.
`timescale 1ns / 1ps

module instrument_code_to_index_core import icti_pkg::*; #(
   parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CHAR_W-1:0]   req_code_char,
   input  logic                req_last_char,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [INDEX_W-1:0]  rsp_code_index,
   output logic                rsp_index_valid
);

   localparam int IDX_W = $clog2(MAX_CODE_LEN);
   localparam int BUF_W = MAX_CODE_LEN * CHAR_W;
   localparam int CLS_W = $bits(icti_class_type);
   localparam int REC_W = BUF_W + IDX_W + CLS_W;

   logic                queue_full;
   logic                push;
   logic [BUF_W-1:0]    push_buf;
   logic [IDX_W-1:0]    push_prefix_len;
   icti_class_type      push_class;
   logic                q_valid;
   logic                q_pop;
   logic [REC_W-1:0]    q_rec;
   logic [BUF_W-1:0]    q_buf;
   logic [IDX_W-1:0]    q_prefix_len;
   icti_class_type      q_class;

   icti_front #(
      .MAX_CODE_LEN(MAX_CODE_LEN)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_code_char   (req_code_char),
      .req_last_char   (req_last_char),
      .queue_full      (queue_full),
      .push            (push),
      .push_buf        (push_buf),
      .push_prefix_len (push_prefix_len),
      .push_class      (push_class)
   );

   icti_queue #(
      .WIDTH(REC_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_buf, push_prefix_len, push_class}),
      .full      (queue_full),
      .pop       (q_pop),
      .pop_data  (q_rec),
      .not_empty (q_valid)
   );

   assign q_buf        = q_rec[REC_W-1 -: BUF_W];
   assign q_prefix_len = q_rec[CLS_W +: IDX_W];
   assign q_class      = q_rec[CLS_W-1:0];

   icti_back #(
      .MAX_CODE_LEN(MAX_CODE_LEN)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_buf           (q_buf),
      .q_prefix_len    (q_prefix_len),
      .q_class         (q_class),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_index  (rsp_code_index),
      .rsp_index_valid (rsp_index_valid)
   );

endmodule

FILE: sim/icti_market_pkg.sv
// Market table, prefix rules and character codes shared by the converter testbench.
`timescale 1ns / 1ps

package icti_market_pkg;

   typedef enum logic [1:0] {
      RULE_DIGITS6,
      RULE_DIGITS5,
      RULE_UPPER,
      RULE_LOWER
   } prefix_rule_type;

   localparam int MARKET_COUNT = 13;
   localparam int NAME_BYTES   = 5;

   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;

   localparam int DIGIT6_SPAN     = 1000000;
   localparam int FUTURES_START   = 5100000;
   localparam int ONE_LETTER_SPAN = 26624;
   localparam int TWO_LETTER_SPAN = 692224;
   localparam int MONTH_SHIFT     = 10;
   localparam int MONTH_LIMIT     = 1023;

   // suffix bytes, first byte in the top byte
   function automatic logic [8*NAME_BYTES-1:0] suffix_name(input int k);
      case (k)
         0:       return 40'h5348000000;
         1:       return 40'h535A000000;
         2:       return 40'h424A000000;
         3:       return 40'h4353490000;
         4:       return 40'h434E490000;
         5:       return 40'h484B000000;
         6:       return 40'h4346464558;
         7:       return 40'h5348464500;
         8:       return 40'h4443450000;
         9:       return 40'h435A434500;
         10:      return 40'h4746450000;
         11:      return 40'h494E450000;
         default: return 40'h5347450000;
      endcase
   endfunction

   function automatic int name_length(input int k);
      case (k)
         0, 1, 2, 5: return 2;
         6:          return 5;
         7, 9:       return 4;
         default:    return 3;
      endcase
   endfunction

   function automatic prefix_rule_type market_rule(input int k);
      case (k)
         0, 1, 2, 3, 4: return RULE_DIGITS6;
         5:             return RULE_DIGITS5;
         6, 9, 12:      return RULE_UPPER;
         default:       return RULE_LOWER;
      endcase
   endfunction

   function automatic int market_base(input int k, input bit two_letters);
      if (k < 5) begin
         return k * DIGIT6_SPAN;
      end
      if (k == 5) begin
         return 5 * DIGIT6_SPAN;
      end
      return FUTURES_START + (k - 6) * (ONE_LETTER_SPAN + TWO_LETTER_SPAN)
             + (two_letters ? ONE_LETTER_SPAN : 0);
   endfunction

endpackage

FILE: sim/instrument_code_to_index_check.sv
// Checker for the converter: predicts each code's index and compares the results.
`timescale 1ns / 1ps

module instrument_code_to_index_check import icti_pkg::*, icti_market_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [CHAR_W-1:0]   req_code_char,
   input  logic                req_last_char,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [INDEX_W-1:0]  rsp_code_index,
   input  logic                rsp_index_valid,
   output int                  fail_count,
   output int                  pending_count,
   output int                  result_count,
   output int                  valid_count
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [INDEX_W-1:0] dense_index;
      logic               index_valid;
   } index_result_type;

   logic [CHAR_W-1:0] code_buf [MAX_CODE_LEN_DEF];
   int                char_count    = 0;
   index_result_type  queued_indexes [$];
   int                mismatches    = 0;
   int                results       = 0;
   int                valid_results = 0;

   function automatic bit is_digit(input logic [CHAR_W-1:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic logic [INDEX_W-1:0] predict_index(input int len);
      int                dot;
      int                sl;
      int                mk;
      int                i;
      int                k;
      int                value;
      int                letters;
      int                alpha;
      int                yy;
      int                mm;
      int                mag;
      bit                hit;
      logic [CHAR_W-1:0] lo;
      logic [39:0]       nm;
      prefix_rule_type   rule;
      if (len < 3 || len > MAX_CODE_LEN_DEF) begin
         return '0;
      end
      dot = -1;
      for (i = len - 1; i >= 0 && dot < 0; i--) begin
         if (code_buf[i] == CHAR_DOT) begin
            dot = i;
         end
      end
      if (dot <= 0 || dot == len - 1) begin
         return '0;
      end
      sl = len - 1 - dot;
      mk = -1;
      for (k = 0; k < MARKET_COUNT && mk < 0; k++) begin
         hit = (sl == name_length(k));
         nm  = suffix_name(k);
         for (i = 0; i < sl && hit; i++) begin
            if (code_buf[dot + 1 + i] != nm[39 - 8 * i -: 8]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            mk = k;
         end
      end
      if (mk < 0) begin
         return '0;
      end
      rule = market_rule(mk);
      if (rule == RULE_DIGITS6 || rule == RULE_DIGITS5) begin
         if (dot != ((rule == RULE_DIGITS6) ? 6 : 5)) begin
            return '0;
         end
         value = 0;
         for (i = 0; i < dot; i++) begin
            if (!is_digit(code_buf[i])) begin
               return '0;
            end
            value = value * 10 + int'(code_buf[i] - CHAR_ZERO);
         end
         return INDEX_W'(market_base(mk, 1'b0) + value);
      end
      // futures: one or two letters of the market's case, then YYMM
      lo      = (rule == RULE_UPPER) ? CHAR_UPPER_A : CHAR_LOWER_A;
      letters = 0;
      alpha   = 0;
      while (letters < 2 && letters < dot && code_buf[letters] >= lo
             && int'(code_buf[letters]) <= int'(lo) + 25) begin
         alpha = alpha * 26 + int'(code_buf[letters] - lo);
         letters++;
      end
      if (letters == 0 || dot != letters + 4) begin
         return '0;
      end
      for (i = letters; i < dot; i++) begin
         if (!is_digit(code_buf[i])) begin
            return '0;
         end
      end
      yy = int'(code_buf[letters] - CHAR_ZERO) * 10 + int'(code_buf[letters + 1] - CHAR_ZERO);
      mm = int'(code_buf[letters + 2] - CHAR_ZERO) * 10 + int'(code_buf[letters + 3] - CHAR_ZERO);
      if (mm < 1 || mm > 12) begin
         return '0;
      end
      mag = yy * 12 + mm - 1;
      if (mag > MONTH_LIMIT) begin
         return '0;
      end
      return INDEX_W'(((alpha << MONTH_SHIFT) | mag) + market_base(mk, letters == 2));
   endfunction

   task automatic take_char(input logic [CHAR_W-1:0] c, input logic last);
      index_result_type res;
      // bytes past the buffer are dropped, the count just sticks one past full
      if (char_count < MAX_CODE_LEN_DEF) begin
         code_buf[char_count] = c;
         char_count++;
      end else begin
         char_count = MAX_CODE_LEN_DEF + 1;
      end
      if (last) begin
         res.dense_index = predict_index(char_count);
         res.index_valid = (res.dense_index != '0);
         queued_indexes.push_back(res);
         char_count = 0;
      end
   endtask

   task automatic check_result();
      index_result_type want;
      results++;
      if (rsp_index_valid === 1'b1) begin
         valid_results++;
      end
      if (queued_indexes.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("%t: unexpected result, index %0d index_valid %b",
                     $time, rsp_code_index, rsp_index_valid);
         end
      end else begin
         want = queued_indexes.pop_front();
         if (rsp_code_index !== want.dense_index || rsp_index_valid !== want.index_valid) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%t: index expected %0d got %0d, index_valid expected %b got %b",
                        $time, want.dense_index, rsp_code_index, want.index_valid,
                        rsp_index_valid);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         char_count = 0;
         foreach (code_buf[i]) begin
            code_buf[i] = '0;
         end
         queued_indexes.delete();
      end else begin
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            take_char(req_code_char, req_last_char);
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            check_result();
         end
      end
      pending_count <= queued_indexes.size();
      fail_count    <= mismatches;
      result_count  <= results;
      valid_count   <= valid_results;
   end

endmodule

FILE: sim/instrument_code_to_index_core_test.sv
// Testbench top for the converter: clock, reset, code stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps

module instrument_code_to_index_core_test;
   import icti_pkg::*;
   import icti_market_pkg::*;

   localparam int RANDOM_CHARS = 160;
   localparam int HOLD_CYCLES  = 200;
   localparam int HOLD_AT_CODE = 8;
   localparam int PAUSE_AT     = 12;
   localparam int TAIL_CYCLES  = 40;
   localparam int CYCLE_LIMIT  = 200000;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_stall;
   logic [CHAR_W-1:0]  req_code_char   = '0;
   logic               req_last_char   = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall       = 1'b0;
   logic [INDEX_W-1:0] rsp_code_index;
   logic               rsp_index_valid;

   int fail_count;
   int pending_count;
   int result_count;
   int valid_count;

   logic [CHAR_W-1:0] code_bytes [$];
   int  codes_sent    = 0;
   int  chars_sent    = 0;
   int  hold_requests = 0;
   int  holds_done    = 0;
   int  cycle_count   = 0;
   bit  gaps_on       = 1'b1;

   instrument_code_to_index_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_code_char   (req_code_char),
      .req_last_char   (req_last_char),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_index  (rsp_code_index),
      .rsp_index_valid (rsp_index_valid)
   );

   instrument_code_to_index_check chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_code_char   (req_code_char),
      .req_last_char   (req_last_char),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_index  (rsp_code_index),
      .rsp_index_valid (rsp_index_valid),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .result_count    (result_count),
      .valid_count     (valid_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still outstanding",
                  cycle_count, pending_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver: short and long stalls, quiet stretches, and a long hold-off on demand
   initial begin
      int stall_left;
      int quiet_left;
      stall_left = 0;
      quiet_left = 0;
      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (quiet_left > 0) begin
               quiet_left--;
            end else if ($urandom_range(0, 99) < 2) begin
               quiet_left = $urandom_range(50, 150);
            end else if ($urandom_range(0, 99) < 20) begin
               stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 3);
            end
         end
      end
   end

   task automatic push_char(input logic [CHAR_W-1:0] c, input bit last);
      int idle;
      req_valid     <= 1'b1;
      req_code_char <= c;
      req_last_char <= last;
      do @(posedge clock); while (req_stall);
      idle = 0;
      if (gaps_on && $urandom_range(0, 99) < 30) begin
         idle = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      end
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
   endtask

   task automatic send_code();
      for (int i = 0; i < code_bytes.size(); i++) begin
         push_char(code_bytes[i], i == code_bytes.size() - 1);
      end
      codes_sent++;
      chars_sent += code_bytes.size();
      code_bytes.delete();
   endtask

   // sender stops until every outstanding result is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      @(posedge clock);
   endtask

   task automatic append_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         code_bytes.push_back(s[i]);
      end
   endtask

   task automatic append_suffix(input int k);
      logic [39:0] nm;
      nm = suffix_name(k);
      for (int i = 0; i < name_length(k); i++) begin
         code_bytes.push_back(nm[39 - 8 * i -: 8]);
      end
   endtask

   task automatic append_two_digits(input int v);
      code_bytes.push_back(CHAR_ZERO + 8'(v / 10));
      code_bytes.push_back(CHAR_ZERO + 8'(v % 10));
   endtask

   task automatic code_for(input string prefix, input int k);
      append_text(prefix);
      code_bytes.push_back(CHAR_DOT);
      append_suffix(k);
      send_code();
   endtask

   task automatic raw_code(input string s);
      append_text(s);
      send_code();
   endtask

   task automatic build_random_code();
      int              k;
      int              n;
      int              r;
      int              letters;
      logic [7:0]      lo;
      prefix_rule_type rule;
      if ($urandom_range(0, 99) < 65) begin
         k    = $urandom_range(0, MARKET_COUNT - 1);
         rule = market_rule(k);
         if (rule == RULE_DIGITS6 || rule == RULE_DIGITS5) begin
            n = (rule == RULE_DIGITS6) ? 6 : 5;
            if ($urandom_range(0, 9) == 0) begin
               n = n + $urandom_range(0, 2) - 1;
            end
            repeat (n) code_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
         end else begin
            r       = $urandom_range(0, 11);
            letters = (r == 0) ? 0 : (r == 1) ? 3 : 1 + (r & 1);
            lo      = (rule == RULE_UPPER) ? CHAR_UPPER_A : CHAR_LOWER_A;
            if ($urandom_range(0, 7) == 0) begin
               lo = (lo == CHAR_UPPER_A) ? CHAR_LOWER_A : CHAR_UPPER_A;
            end
            repeat (letters) code_bytes.push_back(lo + 8'($urandom_range(0, 25)));
            append_two_digits($urandom_range(0, 99));
            append_two_digits(($urandom_range(0, 7) == 0) ? $urandom_range(0, 19)
                                                           : $urandom_range(1, 12));
         end
         code_bytes.push_back(CHAR_DOT);
         append_suffix(k);
         if ($urandom_range(0, 9) == 0) begin
            code_bytes[$urandom_range(0, code_bytes.size() - 1)] = 8'($urandom_range(0, 255));
         end
      end else begin
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 20) : $urandom_range(1, 12);
         repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
               code_bytes.push_back(CHAR_DOT);
            end else if (r < 40) begin
               code_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end else if (r < 55) begin
               code_bytes.push_back(CHAR_UPPER_A + 8'($urandom_range(0, 25)));
            end else if (r < 65) begin
               code_bytes.push_back(CHAR_LOWER_A + 8'($urandom_range(0, 25)));
            end else begin
               code_bytes.push_back(8'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   initial begin
      int random_chars;
      int code_no;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: codes for every market, some range ends, month limits, rejected shapes
      code_for("000000", 0);
      code_for("999999", 4);
      code_for("600519", 1);
      code_for("430047", 2);
      code_for("000300", 3);
      code_for("00001", 5);
      code_for("99999", 5);
      code_for("A0001", 6);
      code_for("ZZ8504", 12);
      code_for("IF2412", 6);
      code_for("ZZ8512", 12);
      code_for("rb2410", 7);
      code_for("m2405", 8);
      code_for("SR2409", 9);
      code_for("si2312", 10);
      code_for("sc2400", 11);
      code_for("ag2413", 7);
      code_for("ag2406", 12);
      code_for("abc2401", 7);
      code_for("60051a", 0);
      code_for("6005", 0);
      code_for("", 0);
      code_for("1234567890", 0);
      code_for("1.600000", 0);
      raw_code("7");
      raw_code("A.");
      raw_code("...");
      raw_code("123456789");
      raw_code("600000.");
      raw_code("600000.XYZ");
      raw_code("12345678901234567890");
      code_bytes.push_back(8'hFF);
      code_bytes.push_back(8'h00);
      code_for("1234", 0);

      random_chars = 0;
      code_no      = 0;
      while (random_chars < RANDOM_CHARS) begin
         code_no++;
         if (code_no % 12 == 0) begin
            gaps_on = !gaps_on;
         end
         if (code_no == HOLD_AT_CODE) begin
            hold_requests++;
         end
         build_random_code();
         random_chars += code_bytes.size();
         send_code();
         if (code_no == PAUSE_AT) begin
            drain();
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d codes (%0d characters); %0d results checked, %0d with a valid index",
               codes_sent, chars_sent, result_count, valid_count);
      $display("covered all markets, rejected shapes, input backpressure and a long output hold");
      if (pending_count != 0) begin
         $display("%0d results never arrived", pending_count);
      end
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/icti_pkg.sv
rtl/icti_front.sv
rtl/icti_queue.sv
rtl/icti_back.sv
rtl/instrument_code_to_index_core.sv
sim/icti_market_pkg.sv
sim/instrument_code_to_index_check.sv
sim/instrument_code_to_index_core_test.sv
